[src/jkse_pkg.sv]
// ----------------------------------------------------------------------------
// jkse_pkg
// Shared types, constants and helpers of the key subdocument extractor.
// ----------------------------------------------------------------------------
package jkse_pkg;

	localparam int KEY_BYTES  = 40;
	localparam int WIN_CELLS  = KEY_BYTES + 3;
	localparam int LEN_W      = 6;
	localparam int IDX_W      = $clog2(WIN_CELLS);
	localparam int KEY_IDX_W  = $clog2(KEY_BYTES);
	localparam int DEPTH_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(255);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_A      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_B      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_C      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_D      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_E      = 3'd5;

	// character codes
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NO_KEY       = 3'd1,
		ST_NO_BRACKET   = 3'd2,
		ST_UNTERMINATED = 3'd3,
		ST_TOO_DEEP     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_SEARCH  = 4'b0001,
		PH_SPACE   = 4'b0010,
		PH_BRACKET = 4'b0100,
		PH_DRAIN   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       doc_end;
	} src_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		status_t    status;
	} res_item_t;

	// byte handed from one window cell to the next
	typedef struct packed {
		logic       vld;
		logic [7:0] data;
	} cell_link_t;

	// control of the window chain
	typedef struct packed {
		logic             shift;
		logic             clear;
		logic [LEN_W-1:0] key_len;
	} cell_ctrl_t;

	typedef logic [KEY_BYTES-1:0][7:0] key_arr_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
	endfunction

endpackage

[src/jkse_cell.sv]
// ----------------------------------------------------------------------------
// jkse_cell
// One window cell: holds one recent byte and checks the byte it is handed
// against the pattern byte for its position.
// ----------------------------------------------------------------------------
module jkse_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [jkse_pkg::IDX_W-1:0]    idx,
	input  jkse_pkg::cell_ctrl_t          ctrl,
	input  jkse_pkg::key_arr_t            key,
	input  jkse_pkg::cell_link_t          link_i,
	output jkse_pkg::cell_link_t          link_o,
	output logic                          ok
);

	logic                             vld_q;
	logic [7:0]                       data_q;
	logic [jkse_pkg::LEN_W:0]         pos;
	logic [jkse_pkg::LEN_W:0]         plen;
	logic [jkse_pkg::LEN_W:0]         kidx_full;
	logic [jkse_pkg::KEY_IDX_W-1:0]   kidx;
	logic [7:0]                       want;

	assign pos       = {1'b0, idx};
	assign plen      = {1'b0, ctrl.key_len} + (jkse_pkg::LEN_W+1)'(3);
	// newest byte sits in cell 0, so the key reads backwards along the chain
	assign kidx_full = {1'b0, ctrl.key_len} + (jkse_pkg::LEN_W+1)'(1) - pos;
	assign kidx      = kidx_full[jkse_pkg::KEY_IDX_W-1:0];

	always_comb begin
		if (pos == '0) begin
			want = jkse_pkg::CH_COLON;
		end else if (pos == (jkse_pkg::LEN_W+1)'(1)) begin
			want = jkse_pkg::CH_QUOTE;
		end else if (pos == plen - (jkse_pkg::LEN_W+1)'(1)) begin
			want = jkse_pkg::CH_QUOTE;
		end else if (kidx_full < (jkse_pkg::LEN_W+1)'(jkse_pkg::KEY_BYTES)) begin
			want = key[kidx];
		end else begin
			want = 8'h00;
		end
	end

	// positions past the pattern do not take part
	assign ok = (pos >= plen) || (link_i.vld && (link_i.data == want));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.clear) begin
			vld_q <= 1'b0;
		end else if (ctrl.shift) begin
			vld_q <= link_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= link_i.data;
		end
	end

	assign link_o.vld  = vld_q;
	assign link_o.data = data_q;

endmodule

[src/jkse_res_queue.sv]
// ----------------------------------------------------------------------------
// jkse_res_queue
// Two-entry result queue that parts the result channel from the byte path.
// ----------------------------------------------------------------------------
module jkse_res_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  jkse_pkg::res_item_t   push_item,
	output logic                  full,
	output logic                  res_valid,
	input  logic                  res_stall,
	output jkse_pkg::res_item_t   res_data
);

	jkse_pkg::res_item_t slot_q [2];
	logic [1:0]          cnt_q;
	logic                pop;
	logic                to_head;

	assign pop       = (cnt_q != 2'd0) && !res_stall;
	assign full      = (cnt_q == 2'd2);
	assign res_valid = (cnt_q != 2'd0);
	assign res_data  = slot_q[0];
	// new item lands in the head slot when the queue is or becomes empty
	assign to_head   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && to_head) begin
			slot_q[0] <= push_item;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
		end
		if (push && !to_head) begin
			slot_q[1] <= push_item;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("result queue overflow");

endmodule

[src/json_key_subdocument_extractor_unit.sv]
// ----------------------------------------------------------------------------
// json_key_subdocument_extractor_unit
// Finds "key": in a byte stream and passes on the bracketed value after it.
//
//   channel  dir  handshake             payload
//   src      in   src_valid/src_stall   src_data   (in_byte, doc_end)
//   res      out  res_valid/res_stall   res_data   (out_byte, byte_valid,
//                                                   last, status)
//   cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one document byte is taken every cycle; the pattern check is a chain of
// 43 window cells, each comparing its byte in the same cycle
// results go through a two-entry queue, so src stalls only when both
// entries wait on a stalled res channel
// reset clears the window, phase, depth and key registers; no clearing pass
// cfg_ready is always high
// ----------------------------------------------------------------------------
module json_key_subdocument_extractor_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              src_valid,
	output logic                              src_stall,
	input  jkse_pkg::src_item_t               src_data,
	output logic                              res_valid,
	input  logic                              res_stall,
	output jkse_pkg::res_item_t               res_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [jkse_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jkse_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// configuration registers
	logic [jkse_pkg::LEN_W-1:0]   key_len_q;
	jkse_pkg::key_arr_t           key_q;
	logic [jkse_pkg::LEN_W-1:0]   key_len_sat;

	// block state
	jkse_pkg::phase_t             phase_q;
	logic                         square_q;
	logic [jkse_pkg::DEPTH_W-1:0] depth_q;

	// byte path
	logic                         acc;
	logic [7:0]                   b;
	logic                         doc_end;
	logic                         match;
	logic                         queue_full;
	logic                         push;
	jkse_pkg::res_item_t          push_item;
	jkse_pkg::cell_ctrl_t         cell_ctrl;
	jkse_pkg::cell_link_t         link [jkse_pkg::WIN_CELLS+1];
	logic [jkse_pkg::WIN_CELLS-1:0] cell_ok;

	// next-state signals
	jkse_pkg::phase_t             phase_d;
	logic                         square_d;
	logic [jkse_pkg::DEPTH_W-1:0] depth_d;
	logic [7:0]                   open_ch;
	logic [7:0]                   close_ch;
	logic [jkse_pkg::DEPTH_W-1:0] depth_dec;

	assign cfg_ready = 1'b1;
	assign src_stall = queue_full;
	assign acc       = src_valid && !src_stall;
	assign b         = src_data.in_byte;
	assign doc_end   = src_data.doc_end;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= '0;
			key_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				jkse_pkg::CFG_KEY_LENGTH: key_len_q <= cfg_data[jkse_pkg::LEN_W-1:0];
				jkse_pkg::CFG_KEY_A:      key_q[7:0]   <= cfg_data;
				jkse_pkg::CFG_KEY_B:      key_q[15:8]  <= cfg_data;
				jkse_pkg::CFG_KEY_C:      key_q[23:16] <= cfg_data;
				jkse_pkg::CFG_KEY_D:      key_q[31:24] <= cfg_data;
				jkse_pkg::CFG_KEY_E:      key_q[39:32] <= cfg_data;
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// key length above KEY_BYTES saturates to KEY_BYTES
	assign key_len_sat = (key_len_q > jkse_pkg::LEN_W'(jkse_pkg::KEY_BYTES)) ?
		jkse_pkg::LEN_W'(jkse_pkg::KEY_BYTES) : key_len_q;

	// ---------------------------------------------------------- window chain
	// cell 0 sees the incoming byte, cell i the byte that came i bytes ago
	assign cell_ctrl.shift   = acc && (phase_q == jkse_pkg::PH_SEARCH);
	assign cell_ctrl.clear   = acc && doc_end;
	assign cell_ctrl.key_len = key_len_sat;

	assign link[0].vld  = 1'b1;
	assign link[0].data = b;

	for (genvar i = 0; i < jkse_pkg::WIN_CELLS; i++) begin : g_cell
		jkse_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (jkse_pkg::IDX_W'(i)),
			.ctrl   (cell_ctrl),
			.key    (key_q),
			.link_i (link[i]),
			.link_o (link[i+1]),
			.ok     (cell_ok[i])
		);
	end

	// full pattern ends on the current byte
	assign match = &cell_ok;

	// ------------------------------------------------------------ phase logic
	assign open_ch   = square_q ? jkse_pkg::CH_LBRACK : jkse_pkg::CH_LBRACE;
	assign close_ch  = square_q ? jkse_pkg::CH_RBRACK : jkse_pkg::CH_RBRACE;
	assign depth_dec = (depth_q != '0) ? depth_q - jkse_pkg::DEPTH_W'(1) : depth_q;

	always_comb begin
		phase_d   = phase_q;
		square_d  = square_q;
		depth_d   = depth_q;
		push      = 1'b0;
		push_item = '{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b0,
			status: jkse_pkg::ST_OK};
		case (phase_q)
			jkse_pkg::PH_SEARCH: begin
				if (match) begin
					if (doc_end) begin
						push = 1'b1;
						push_item.last   = 1'b1;
						push_item.status = jkse_pkg::ST_UNTERMINATED;
					end else begin
						phase_d = jkse_pkg::PH_SPACE;
					end
				end else if (doc_end) begin
					push = 1'b1;
					push_item.last   = 1'b1;
					push_item.status = jkse_pkg::ST_NO_KEY;
				end
			end
			jkse_pkg::PH_SPACE: begin
				push = 1'b1;
				if (jkse_pkg::is_space(b) ||
						b == jkse_pkg::CH_LBRACE || b == jkse_pkg::CH_LBRACK) begin
					if (!jkse_pkg::is_space(b)) begin
						square_d = (b == jkse_pkg::CH_LBRACK);
						depth_d  = jkse_pkg::DEPTH_W'(1);
						if (!doc_end) begin
							phase_d = jkse_pkg::PH_BRACKET;
						end
					end
					if (doc_end) begin
						push_item.last   = 1'b1;
						push_item.status = jkse_pkg::ST_UNTERMINATED;
					end else begin
						push_item.out_byte   = b;
						push_item.byte_valid = 1'b1;
					end
				end else begin
					push_item.last   = 1'b1;
					push_item.status = jkse_pkg::ST_NO_BRACKET;
					phase_d = jkse_pkg::PH_DRAIN;
				end
			end
			jkse_pkg::PH_BRACKET: begin
				push = 1'b1;
				if (b == open_ch && depth_q >= jkse_pkg::MAX_DEPTH) begin
					push_item.last   = 1'b1;
					push_item.status = jkse_pkg::ST_TOO_DEEP;
					phase_d = jkse_pkg::PH_DRAIN;
				end else if (b == close_ch && depth_dec == '0) begin
					// matching close ends the value
					depth_d = depth_dec;
					push_item.out_byte   = b;
					push_item.byte_valid = 1'b1;
					push_item.last       = 1'b1;
					phase_d = jkse_pkg::PH_DRAIN;
				end else begin
					if (b == open_ch) begin
						depth_d = depth_q + jkse_pkg::DEPTH_W'(1);
					end else if (b == close_ch) begin
						depth_d = depth_dec;
					end
					if (doc_end) begin
						push_item.last   = 1'b1;
						push_item.status = jkse_pkg::ST_UNTERMINATED;
					end else begin
						push_item.out_byte   = b;
						push_item.byte_valid = 1'b1;
					end
				end
			end
			jkse_pkg::PH_DRAIN: begin
				// bytes dropped until the document ends
			end
			default: begin
				phase_d = jkse_pkg::PH_SEARCH;
			end
		endcase
		// end of document starts over, registers kept
		if (doc_end) begin
			phase_d  = jkse_pkg::PH_SEARCH;
			square_d = 1'b0;
			depth_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= jkse_pkg::PH_SEARCH;
			square_q <= 1'b0;
			depth_q  <= '0;
		end else if (acc) begin
			phase_q  <= phase_d;
			square_q <= square_d;
			depth_q  <= depth_d;
		end
	end

	// ----------------------------------------------------------- result queue
	jkse_res_queue u_res_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc && push),
		.push_item (push_item),
		.full      (queue_full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// ------------------------------------------------------------- assertions
	// depth is only nonzero once a bracket has been seen
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == jkse_pkg::PH_SEARCH) |-> (depth_q == '0))
		else $error("depth nonzero while searching");

	// inside brackets the depth never reaches zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == jkse_pkg::PH_BRACKET) |-> (depth_q != '0))
		else $error("zero depth inside brackets");

	// a transfer without a byte always closes the document
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.byte_valid) |-> res_data.last)
		else $error("empty result without last");

	// an error status comes only with last
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.status != jkse_pkg::ST_OK) |-> res_data.last)
		else $error("error status without last");

	// end of document always brings the block back to searching
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && doc_end) |=> (phase_q == jkse_pkg::PH_SEARCH))
		else $error("phase not reset at document end");

endmodule
